/* src/cpd_pkg.sv */
// Package for the command packet deframer: shared types and codes.
// Used by cpd_csr, cpd_param_mem, cpd_ctrl, cpd_checker and the top level.
package cpd_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_BYTE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PACKET  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHECK_EN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_LOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_HIGH  = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

   // header + command + checksum bytes around the parameters
   localparam logic [8:0] FRAME_OVERHEAD = 9'd3;

   typedef struct packed {
      logic [7:0]  header_byte;
      logic [7:0]  max_packet_size;
      logic        check_enable;
      logic [63:0] count_table_low;
      logic [63:0] count_table_high;
   } cfg_type;

   typedef struct packed {
      logic [7:0] command;
      logic [3:0] param_count;
      logic [3:0] param_index;
      logic [7:0] param_byte;
      logic       has_param;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       wr_en;
      logic [3:0] wr_addr;
      logic [7:0] wr_data;
      logic       rd_en;
      logic [3:0] rd_addr;
   } mem_req_type;

endpackage

/* src/cpd_csr.sv */
// Configuration registers of the deframer, written through the csr port.
// Depends on cpd_pkg.
module cpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [cpd_pkg::CSR_INDEX_W-1:0]     wr_index,
   input  logic [cpd_pkg::CSR_DATA_W-1:0]      wr_data,
   output cpd_pkg::cfg_type                    cfg
);
   import cpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_HEADER_BYTE: cfg_in.header_byte      = wr_data[7:0];
            REG_MAX_PACKET:  cfg_in.max_packet_size  = wr_data[7:0];
            REG_CHECK_EN:    cfg_in.check_enable     = wr_data[0];
            REG_TABLE_LOW:   cfg_in.count_table_low  = wr_data;
            REG_TABLE_HIGH:  cfg_in.count_table_high = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte      <= 8'd170;
         cfg_ff.max_packet_size  <= 8'd255;
         cfg_ff.check_enable     <= 1'b1;
         cfg_ff.count_table_low  <= '0;
         cfg_ff.count_table_high <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/cpd_param_mem.sv */
// Parameter byte store: one write port, one registered read port.
// Depends on cpd_pkg.
module cpd_param_mem #(
   parameter int unsigned MAX_PARAMS = 15
) (
   input  logic                  clock,
   input  cpd_pkg::mem_req_type  req,
   output logic [7:0]            rd_data
);
   import cpd_pkg::*;

   localparam int unsigned AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   logic [7:0] store_ff [MAX_PARAMS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         store_ff[req.wr_addr[AW-1:0]] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= store_ff[req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/cpd_ctrl.sv */
// Packet parser and result sequencer: header hunt, command lookup, parameter
// capture into cpd_param_mem, checksum compare and result output register.
// Depends on cpd_pkg.
module cpd_ctrl #(
   parameter int unsigned MAX_PARAMS   = 15,
   parameter int unsigned NUM_COMMANDS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cpd_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   output cpd_pkg::mem_req_type  mem_req,
   input  logic [7:0]            mem_rd_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cpd_pkg::rsp_type      out_rsp
);
   import cpd_pkg::*;

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_CMD   = 3'd1;
   localparam logic [2:0] PH_PARAM = 3'd2;
   localparam logic [2:0] PH_CHECK = 3'd3;
   localparam logic [2:0] PH_READ  = 3'd4;
   localparam logic [2:0] PH_SEND  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [3:0] exp_ff, exp_in;
   logic [3:0] rcv_ff, rcv_in;
   logic [7:0] xor_ff, xor_in;
   logic [3:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       out_free;
   logic       accept;
   logic [3:0] lookup_cnt;
   logic [4:0] rcv_next;
   logic       too_long;

   assign out_free = !out_valid_ff || out_ready;
   assign in_ready = (state_ff == PH_HUNT || state_ff == PH_CMD ||
                      state_ff == PH_PARAM || state_ff == PH_CHECK) && out_free;
   assign accept   = in_valid && in_ready;

   assign lookup_cnt = in_byte[4] ? cfg.count_table_high[{in_byte[3:0], 2'b00} +: 4]
                                  : cfg.count_table_low[{in_byte[3:0], 2'b00} +: 4];
   assign too_long = ({5'd0, lookup_cnt} + FRAME_OVERHEAD > {1'b0, cfg.max_packet_size}) ||
                     ({1'b0, lookup_cnt} > 5'(MAX_PARAMS));
   assign rcv_next = {1'b0, rcv_ff} + 5'd1;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      exp_in       = exp_ff;
      rcv_in       = rcv_ff;
      xor_in       = xor_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !out_ready;
      rsp_in       = rsp_ff;
      mem_req      = '0;
      mem_req.wr_addr = rcv_ff;
      mem_req.wr_data = in_byte;
      mem_req.rd_addr = idx_ff;

      // single status or empty result, filled in below where needed
      case (state_ff)
         PH_HUNT: begin
            if (accept && in_byte == cfg.header_byte) begin
               xor_in   = in_byte;
               state_in = PH_CMD;
            end
         end
         PH_CMD: begin
            if (accept) begin
               cmd_in = in_byte;
               xor_in = xor_ff ^ in_byte;
               rcv_in = '0;
               rsp_in = '0;
               rsp_in.command = in_byte;
               rsp_in.last    = 1'b1;
               if ({1'b0, in_byte} >= 9'(NUM_COMMANDS)) begin
                  exp_in        = '0;
                  rsp_in.status = STATUS_UNKNOWN;
                  out_valid_in  = 1'b1;
                  state_in      = PH_HUNT;
               end else begin
                  exp_in             = lookup_cnt;
                  rsp_in.param_count = lookup_cnt;
                  if (too_long) begin
                     rsp_in.status = STATUS_TOO_LONG;
                     out_valid_in  = 1'b1;
                     state_in      = PH_HUNT;
                  end else if (lookup_cnt == 4'd0) begin
                     if (cfg.check_enable) begin
                        state_in = PH_CHECK;
                     end else begin
                        rsp_in.status = STATUS_OK;
                        out_valid_in  = 1'b1;
                        state_in      = PH_HUNT;
                     end
                  end else begin
                     state_in = PH_PARAM;
                  end
               end
            end
         end
         PH_PARAM: begin
            if (accept) begin
               mem_req.wr_en = 1'b1;
               xor_in        = xor_ff ^ in_byte;
               rcv_in        = rcv_next[3:0];
               if (rcv_next >= {1'b0, exp_ff}) begin
                  idx_in   = '0;
                  state_in = cfg.check_enable ? PH_CHECK : PH_READ;
               end
            end
         end
         PH_CHECK: begin
            if (accept) begin
               rsp_in             = '0;
               rsp_in.command     = cmd_ff;
               rsp_in.param_count = exp_ff;
               rsp_in.last        = 1'b1;
               idx_in             = '0;
               if (in_byte != xor_ff) begin
                  rsp_in.status = STATUS_BAD_SUM;
                  out_valid_in  = 1'b1;
                  state_in      = PH_HUNT;
               end else if (exp_ff == 4'd0) begin
                  rsp_in.status = STATUS_OK;
                  out_valid_in  = 1'b1;
                  state_in      = PH_HUNT;
               end else begin
                  state_in = PH_READ;
               end
            end
         end
         PH_READ: begin
            mem_req.rd_en = 1'b1;
            state_in      = PH_SEND;
         end
         PH_SEND: begin
            // read data stays put until the output register frees up
            if (out_free) begin
               rsp_in.command     = cmd_ff;
               rsp_in.param_count = exp_ff;
               rsp_in.param_index = idx_ff;
               rsp_in.param_byte  = mem_rd_data;
               rsp_in.has_param   = 1'b1;
               rsp_in.status      = STATUS_OK;
               rsp_in.last        = ({1'b0, idx_ff} + 5'd1 == {1'b0, exp_ff});
               out_valid_in       = 1'b1;
               if ({1'b0, idx_ff} + 5'd1 == {1'b0, exp_ff}) begin
                  state_in = PH_HUNT;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = PH_READ;
               end
            end
         end
         default: state_in = PH_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_HUNT;
         cmd_ff       <= '0;
         exp_ff       <= '0;
         rcv_ff       <= '0;
         xor_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         exp_ff       <= exp_in;
         rcv_ff       <= rcv_in;
         xor_ff       <= xor_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

/* src/command_packet_deframer.sv */
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata[7:0] rx_byte
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata, tuser {status,has_param}, tlast
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_data (always ready)
//
//  Received bytes are accepted while req_tready is high. A good packet with N
//  parameters is sent as N beats, each a param store read, then an output
//  load; req_tready stays low while those beats go out. Status and empty
//  results go straight to the output register. A stalled rsp holds its beat
//  and keeps req_tready low until that beat is taken.
//  Reset (synchronous) returns to header hunt; the param store needs no clear.
//  Depends on cpd_pkg, cpd_csr, cpd_param_mem, cpd_ctrl.
module command_packet_deframer #(
   parameter int unsigned MAX_PARAMS   = 15,
   parameter int unsigned NUM_COMMANDS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] command, [11:8] param_count, [15:12] param_index, [23:16] param_byte
   output logic [23:0]                       rsp_tdata,
   output logic [2:0]                        rsp_tuser,   // [0] has_param, [2:1] status
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cpd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cpd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import cpd_pkg::*;

   cfg_type     cfg;
   mem_req_type mem_req;
   logic [7:0]  mem_rd_data;
   rsp_type     rsp;

   assign csr_ready = 1'b1;

   cpd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   cpd_param_mem #(.MAX_PARAMS(MAX_PARAMS)) u_mem (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (mem_rd_data)
   );

   cpd_ctrl #(.MAX_PARAMS(MAX_PARAMS), .NUM_COMMANDS(NUM_COMMANDS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_rsp     (rsp)
   );

   assign rsp_tdata = {rsp.param_byte, rsp.param_index, rsp.param_count, rsp.command};
   assign rsp_tuser = {rsp.status, rsp.has_param};
   assign rsp_tlast = rsp.last;

endmodule

/* src/cpd_checker.sv */
// Port-level checks for command_packet_deframer, bound to the top level.
// Depends on cpd_pkg.
module cpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import cpd_pkg::*;

   // a stalled beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // error beats are single, empty runs
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] != STATUS_OK |-> rsp_tlast && !rsp_tuser[0])
      else $error("error beat not a lone empty beat");

   // parameter beats stay inside the count and end exactly on the last one
   a_param_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
      rsp_tdata[15:12] < rsp_tdata[11:8] &&
      rsp_tlast == ({1'b0, rsp_tdata[15:12]} + 5'd1 == {1'b0, rsp_tdata[11:8]}))
      else $error("param index or last flag inconsistent with count");

endmodule

bind command_packet_deframer cpd_checker u_cpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
